// ===== rtl/mjp_pkg.sv =====
// Shared types, command codes and helpers for the mouse/joystick port reader.
package mjp_pkg;

	typedef enum logic [1:0] {
		CMD_ATTACH = 2'd0,
		CMD_DETACH = 2'd1,
		CMD_PIN8   = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	localparam logic [7:0] SAT_MAX = 8'h7F;
	localparam logic [7:0] SAT_MIN = 8'h80;

	typedef struct packed {
		logic       present;
		logic       strobe;
		logic [1:0] phase;
		logic [7:0] dx;
		logic [7:0] dy;
		logic       left;
		logic       right;
	} port_state_t;

	// event applied to the mouse state, one per processed transaction
	typedef struct packed {
		logic       valid;
		cmd_t       cmd;
		logic       port;
		logic [7:0] dx;
		logic [7:0] dy;
		logic       left;
		logic       right;
		logic       level;
	} event_t;

	function automatic logic [7:0] saturate8(input logic signed [15:0] v);
		logic [7:0] r;
		if (v < -16'sd128) begin
			r = SAT_MIN;
		end else if (v > 16'sd127) begin
			r = SAT_MAX;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/mjp_ports.sv =====
// Per-port mouse state registers and their update on attach, detach and pin-8 events.
module mjp_ports (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mjp_pkg::event_t                 ev,
	output mjp_pkg::port_state_t [1:0]      st
);

	mjp_pkg::port_state_t [1:0] st_q;
	mjp_pkg::port_state_t [1:0] st_d;

	always_comb begin
		st_d = st_q;
		for (int p = 0; p < 2; p++) begin
			if (ev.valid && (ev.port == p[0])) begin
				case (ev.cmd)
					mjp_pkg::CMD_ATTACH: begin
						st_d[p].present = 1'b1;
						st_d[p].phase   = 2'd0;
						st_d[p].dx      = ev.dx;
						st_d[p].dy      = ev.dy;
						st_d[p].left    = ev.left;
						st_d[p].right   = ev.right;
					end
					mjp_pkg::CMD_DETACH: begin
						st_d[p].present = 1'b0;
						st_d[p].phase   = 2'd0;
						st_d[p].dx      = 8'd0;
						st_d[p].dy      = 8'd0;
						st_d[p].left    = 1'b0;
						st_d[p].right   = 1'b0;
					end
					mjp_pkg::CMD_PIN8: begin
						if (ev.level != st_q[p].strobe) begin
							st_d[p].strobe = ev.level;
							if (st_q[p].present) begin
								st_d[p].phase = st_q[p].phase + 2'd1;
								// phase wrap ends the report, deltas consumed
								if (st_q[p].phase == 2'd3) begin
									st_d[p].dx = 8'd0;
									st_d[p].dy = 8'd0;
								end
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else begin
			st_q <= st_d;
		end
	end

	assign st = st_q;

endmodule

// ===== rtl/mjp_format.sv =====
// Port A read value: selected port's mouse nibble or joystick bits, trigger masks, tape bit.
module mjp_format (
	input  mjp_pkg::port_state_t [1:0] st,
	input  logic [5:0]                 joy_first,
	input  logic [5:0]                 joy_second,
	input  logic [7:0]                 select_latch,
	input  logic                       tape_in,
	output logic [7:0]                 port_a_data
);

	mjp_pkg::port_state_t ps;
	logic                 sel;
	logic [5:0]           bits;
	logic [3:0]           nib;
	logic                 en_a;
	logic                 en_b;

	always_comb begin
		sel = select_latch[6];
		ps  = st[sel];
		case (ps.phase)
			2'd0:    nib = ps.dx[7:4];
			2'd1:    nib = ps.dx[3:0];
			2'd2:    nib = ps.dy[7:4];
			default: nib = ps.dy[3:0];
		endcase
		if (ps.present) begin
			bits = {~ps.right, ~ps.left, nib};
		end else begin
			bits = sel ? joy_second : joy_first;
		end
		en_a = sel ? select_latch[2] : select_latch[0];
		en_b = sel ? select_latch[3] : select_latch[1];
		if (!en_a) begin
			bits[4] = 1'b0;
		end
		if (!en_b) begin
			bits[5] = 1'b0;
		end
		port_a_data = {tape_in, 1'b1, bits};
	end

endmodule

// ===== rtl/mouse_joystick_port_reader.sv =====
// Top level: input register, mouse state update, port A read and result register.
// A read transaction passes the input register and then the result register before it shows on out_valid.
// Throughput: one transaction per cycle; a read waits only while the result register stalls.
// Attach, detach and pin-8 transactions give no result and never stall.
// arst_n clears the input and result valid flags and all mouse state (detached, phase 0).
module mouse_joystick_port_reader (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic        port,
	input  logic [15:0] move_x,
	input  logic [15:0] move_y,
	input  logic        button_left,
	input  logic        button_right,
	input  logic        pin_level,
	input  logic [5:0]  joy_first,
	input  logic [5:0]  joy_second,
	input  logic [7:0]  select_latch,
	input  logic        tape_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  port_a_data
);

	logic               valid_s1;
	mjp_pkg::cmd_t      cmd_s1;
	logic               port_s1;
	logic [15:0]        move_x_s1;
	logic [15:0]        move_y_s1;
	logic               left_s1;
	logic               right_s1;
	logic               level_s1;
	logic [5:0]         joy_first_s1;
	logic [5:0]         joy_second_s1;
	logic [7:0]         latch_s1;
	logic               tape_s1;

	logic               out_valid_q;
	logic [7:0]         data_q;
	logic [7:0]         data_d;
	logic               is_read_s1;
	logic               go_s1;
	logic               take_in;

	mjp_pkg::event_t            ev;
	mjp_pkg::port_state_t [1:0] st;

	assign is_read_s1 = (cmd_s1 == mjp_pkg::CMD_READ);
	assign go_s1      = valid_s1 && (!is_read_s1 || !out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || go_s1;
	assign take_in    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			cmd_s1        <= mjp_pkg::cmd_t'(cmd);
			port_s1       <= port;
			move_x_s1     <= move_x;
			move_y_s1     <= move_y;
			left_s1       <= button_left;
			right_s1      <= button_right;
			level_s1      <= pin_level;
			joy_first_s1  <= joy_first;
			joy_second_s1 <= joy_second;
			latch_s1      <= select_latch;
			tape_s1       <= tape_in;
		end
	end

	always_comb begin
		ev.valid = go_s1;
		ev.cmd   = cmd_s1;
		ev.port  = port_s1;
		ev.dx    = mjp_pkg::saturate8(move_x_s1);
		ev.dy    = mjp_pkg::saturate8(move_y_s1);
		ev.left  = left_s1;
		ev.right = right_s1;
		ev.level = level_s1;
	end

	mjp_ports u_ports (
		.clk    (clk),
		.arst_n (arst_n),
		.ev     (ev),
		.st     (st)
	);

	mjp_format u_format (
		.st           (st),
		.joy_first    (joy_first_s1),
		.joy_second   (joy_second_s1),
		.select_latch (latch_s1),
		.tape_in      (tape_s1),
		.port_a_data  (data_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && is_read_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && is_read_s1) begin
			data_q <= data_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign port_a_data = data_q;

endmodule

// ===== rtl/mjp_checker.sv =====
// Port-level assertions for the mouse/joystick port reader, bound to the top level.
module mjp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] port_a_data
);

	// a stalled result transaction holds its data
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(port_a_data))
		else $error("result transaction changed while stalled");

	// bit 6 of port A always reads high
	a_bit6: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> port_a_data[6])
		else $error("port A bit 6 low");

	// no result can appear right at reset release
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid at reset release");

	// an empty pipe always takes a transaction
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(in_valid) && !out_valid |-> in_ready)
		else $error("not ready while empty");

endmodule

bind mouse_joystick_port_reader mjp_checker u_mjp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.port_a_data (port_a_data)
);

// ===== test/testbench.sv =====
// Testbench for mouse_joystick_port_reader: queued stimulus, port-state predictor, result checker.
`timescale 1ns / 1ps

module testbench;

	localparam int RANDOM_ITEMS = 700;
	localparam int HOLDOFF_LEN  = 300;
	localparam int STALL_LIMIT  = 2000;

	typedef enum {MODE_FREE, MODE_SEND_IDLE, MODE_RECV_STALL, MODE_BOTH_IDLE, MODE_HOLDOFF} pace_t;

	typedef struct {
		mjp_pkg::cmd_t      op;
		logic               port;
		logic signed [15:0] mx;
		logic signed [15:0] my;
		logic               bl;
		logic               br;
		logic               lvl;
		logic [5:0]         joy1;
		logic [5:0]         joy2;
		logic [7:0]         latch;
		logic               tape;
		pace_t              mode;
	} port_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = '0;
	logic        port = 1'b0;
	logic [15:0] move_x = '0;
	logic [15:0] move_y = '0;
	logic        button_left = 1'b0;
	logic        button_right = 1'b0;
	logic        pin_level = 1'b0;
	logic [5:0]  joy_first = '0;
	logic [5:0]  joy_second = '0;
	logic [7:0]  select_latch = '0;
	logic        tape_in = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  port_a_data;

	mouse_joystick_port_reader dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.port(port),
		.move_x(move_x),
		.move_y(move_y),
		.button_left(button_left),
		.button_right(button_right),
		.pin_level(pin_level),
		.joy_first(joy_first),
		.joy_second(joy_second),
		.select_latch(select_latch),
		.tape_in(tape_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.port_a_data(port_a_data)
	);

	port_event_t port_events[$];
	logic [7:0]  port_a_expected[$];
	pace_t       drive_mode = MODE_FREE;
	pace_t       fill_mode = MODE_FREE;
	logic        gen_strobe[2] = '{1'b0, 1'b0};
	int          total_events = 0;
	int          accepted_events = 0;
	int          holdoff_cycles = 0;
	int          stall_cycles = 0;
	int          errors = 0;

	// predicted per-port mouse state
	logic       mouse_on[2] = '{1'b0, 1'b0};
	logic       strobe[2] = '{1'b0, 1'b0};
	logic [1:0] phase[2] = '{2'd0, 2'd0};
	logic [7:0] dx[2] = '{8'd0, 8'd0};
	logic [7:0] dy[2] = '{8'd0, 8'd0};
	logic       btn_l[2] = '{1'b0, 1'b0};
	logic       btn_r[2] = '{1'b0, 1'b0};

	function automatic logic [7:0] clamp_delta(logic signed [15:0] v);
		if (v < -16'sd128)
			return mjp_pkg::SAT_MIN;
		if (v > 16'sd127)
			return mjp_pkg::SAT_MAX;
		return v[7:0];
	endfunction

	task automatic apply_port_event(port_event_t t);
		logic       sel;
		logic [5:0] bits;
		logic [3:0] nib;
		case (t.op)
			mjp_pkg::CMD_ATTACH: begin
				mouse_on[t.port] = 1'b1;
				phase[t.port] = 2'd0;
				dx[t.port] = clamp_delta(t.mx);
				dy[t.port] = clamp_delta(t.my);
				btn_l[t.port] = t.bl;
				btn_r[t.port] = t.br;
			end
			mjp_pkg::CMD_DETACH: begin
				mouse_on[t.port] = 1'b0;
				phase[t.port] = 2'd0;
				dx[t.port] = 8'd0;
				dy[t.port] = 8'd0;
				btn_l[t.port] = 1'b0;
				btn_r[t.port] = 1'b0;
			end
			mjp_pkg::CMD_PIN8: begin
				if (t.lvl != strobe[t.port]) begin
					strobe[t.port] = t.lvl;
					if (mouse_on[t.port]) begin
						phase[t.port] = phase[t.port] + 2'd1;
						if (phase[t.port] == 2'd0) begin
							dx[t.port] = 8'd0;
							dy[t.port] = 8'd0;
						end
					end
				end
			end
			default: begin
				sel = t.latch[6];
				if (mouse_on[sel]) begin
					case (phase[sel])
						2'd0: nib = dx[sel][7:4];
						2'd1: nib = dx[sel][3:0];
						2'd2: nib = dy[sel][7:4];
						default: nib = dy[sel][3:0];
					endcase
					bits = {~btn_r[sel], ~btn_l[sel], nib};
				end else begin
					bits = sel ? t.joy2 : t.joy1;
				end
				if (!t.latch[sel ? 2 : 0])
					bits[4] = 1'b0;
				if (!t.latch[sel ? 3 : 1])
					bits[5] = 1'b0;
				port_a_expected.push_back({t.tape, 1'b1, bits});
			end
		endcase
	endtask

	function automatic logic signed [15:0] random_move();
		if ($urandom_range(1))
			return 16'($urandom);
		return 16'(int'($urandom_range(400)) - 200);
	endfunction

	function automatic port_event_t random_fields();
		port_event_t t;
		t.op = mjp_pkg::cmd_t'($urandom_range(3));
		t.port = 1'($urandom);
		t.mx = random_move();
		t.my = random_move();
		t.bl = 1'($urandom);
		t.br = 1'($urandom);
		t.lvl = 1'($urandom);
		t.joy1 = 6'($urandom);
		t.joy2 = 6'($urandom);
		t.latch = 8'($urandom);
		t.tape = 1'($urandom);
		t.mode = MODE_FREE;
		return t;
	endfunction

	task automatic enqueue(port_event_t t);
		t.mode = fill_mode;
		if (t.op == mjp_pkg::CMD_PIN8)
			gen_strobe[t.port] = t.lvl;
		port_events.push_back(t);
		total_events++;
	endtask

	task automatic enqueue_directed(mjp_pkg::cmd_t op, logic p, logic [15:0] mx,
			logic [15:0] my, logic bl, logic br, logic lvl, logic [7:0] latch);
		port_event_t t;
		t = random_fields();
		t.op = op;
		t.port = p;
		t.mx = mx;
		t.my = my;
		t.bl = bl;
		t.br = br;
		t.lvl = lvl;
		t.latch = latch;
		enqueue(t);
	endtask

	function automatic bit sender_waits(pace_t m);
		if (m == MODE_SEND_IDLE)
			return $urandom_range(99) < 71;
		if (m == MODE_BOTH_IDLE)
			return $urandom_range(99) < 10;
		return 1'b0;
	endfunction

	function automatic bit receiver_stalls(pace_t m);
		if (m == MODE_RECV_STALL)
			return $urandom_range(99) < 71;
		if (m == MODE_BOTH_IDLE)
			return $urandom_range(99) < 10;
		return 1'b0;
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk) begin : drive_proc
		port_event_t nxt;
		port_event_t cur;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				apply_port_event(cur);
				accepted_events++;
			end
			if (!in_valid || in_ready) begin
				if (port_events.size() > 0 && !sender_waits(port_events[0].mode)) begin
					nxt = port_events.pop_front();
					cur = nxt;
					drive_mode <= nxt.mode;
					in_valid <= 1'b1;
					cmd <= nxt.op;
					port <= nxt.port;
					move_x <= nxt.mx;
					move_y <= nxt.my;
					button_left <= nxt.bl;
					button_right <= nxt.br;
					pin_level <= nxt.lvl;
					joy_first <= nxt.joy1;
					joy_second <= nxt.joy2;
					select_latch <= nxt.latch;
					tape_in <= nxt.tape;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin : sink_proc
		logic [7:0] want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (port_a_expected.size() == 0) begin
					$error("unexpected port_a_data %h", port_a_data);
					errors++;
				end else begin
					want = port_a_expected.pop_front();
					if (port_a_data !== want) begin
						$error("port_a_data: expected %h, actual %h", want, port_a_data);
						errors++;
					end
				end
			end
			if (drive_mode == MODE_HOLDOFF && holdoff_cycles < HOLDOFF_LEN) begin
				holdoff_cycles++;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !receiver_stalls(drive_mode);
			end
		end
	end

	// watchdog: cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n)
			stall_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ? 0 : stall_cycles + 1;
	end

	initial begin
		port_event_t t;
		int          dir_n;
		int          steps;
		logic        p;

		// directed: joystick reads, trigger enables, saturation, phase walk, wrap, detach
		enqueue_directed(mjp_pkg::CMD_READ, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h00);
		enqueue_directed(mjp_pkg::CMD_READ, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h0F);
		enqueue_directed(mjp_pkg::CMD_READ, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 8'hFF);
		enqueue_directed(mjp_pkg::CMD_PIN8, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 8'h00);
		enqueue_directed(mjp_pkg::CMD_ATTACH, 1'b0, 16'h7FFF, 16'h8000, 1'b1, 1'b0, 1'b0, 8'h00);
		enqueue_directed(mjp_pkg::CMD_READ, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h03);
		enqueue_directed(mjp_pkg::CMD_PIN8, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 8'h00);
		enqueue_directed(mjp_pkg::CMD_READ, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h03);
		enqueue_directed(mjp_pkg::CMD_PIN8, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h00);
		enqueue_directed(mjp_pkg::CMD_READ, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 8'hB3);
		enqueue_directed(mjp_pkg::CMD_PIN8, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 8'h00);
		enqueue_directed(mjp_pkg::CMD_READ, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h01);
		enqueue_directed(mjp_pkg::CMD_PIN8, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h00);
		enqueue_directed(mjp_pkg::CMD_READ, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h02);
		enqueue_directed(mjp_pkg::CMD_PIN8, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 8'h00);
		enqueue_directed(mjp_pkg::CMD_READ, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h03);
		enqueue_directed(mjp_pkg::CMD_ATTACH, 1'b1, 16'hFF80, 16'h007F, 1'b0, 1'b1, 1'b0, 8'h00);
		enqueue_directed(mjp_pkg::CMD_READ, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h4C);
		enqueue_directed(mjp_pkg::CMD_ATTACH, 1'b1, 16'hFF7F, 16'h0080, 1'b1, 1'b1, 1'b0, 8'h00);
		enqueue_directed(mjp_pkg::CMD_PIN8, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 8'h00);
		enqueue_directed(mjp_pkg::CMD_READ, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h4C);
		enqueue_directed(mjp_pkg::CMD_ATTACH, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h00);
		enqueue_directed(mjp_pkg::CMD_READ, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h03);
		enqueue_directed(mjp_pkg::CMD_DETACH, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h00);
		enqueue_directed(mjp_pkg::CMD_READ, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h4F);
		enqueue_directed(mjp_pkg::CMD_DETACH, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h00);
		enqueue_directed(mjp_pkg::CMD_READ, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h0F);
		dir_n = total_events;

		// random: mostly attach + strobe walks with reads, some detach and noise
		while (total_events - dir_n < RANDOM_ITEMS) begin
			fill_mode = pace_t'(((total_events - dir_n) * 5) / RANDOM_ITEMS);
			t = random_fields();
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: begin
					p = 1'($urandom);
					t.op = mjp_pkg::CMD_ATTACH;
					t.port = p;
					enqueue(t);
					steps = $urandom_range(2, 9);
					repeat (steps) begin
						if ($urandom_range(3) != 0) begin
							t = random_fields();
							t.op = mjp_pkg::CMD_READ;
							if ($urandom_range(7) != 0)
								t.latch[6] = p;
							enqueue(t);
						end
						t = random_fields();
						t.op = mjp_pkg::CMD_PIN8;
						t.port = p;
						t.lvl = ($urandom_range(99) < 85) ? !gen_strobe[p] : gen_strobe[p];
						enqueue(t);
					end
				end
				6: begin
					t.op = mjp_pkg::CMD_DETACH;
					enqueue(t);
				end
				default: enqueue(t);
			endcase
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while ((accepted_events < total_events || port_a_expected.size() > 0)
				&& stall_cycles < STALL_LIMIT)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (stall_cycles >= STALL_LIMIT) begin
			$error("no transaction for %0d cycles", STALL_LIMIT);
			errors++;
		end
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/mjp_pkg.sv
rtl/mjp_ports.sv
rtl/mjp_format.sv
rtl/mouse_joystick_port_reader.sv
rtl/mjp_checker.sv
test/testbench.sv
